// ===== src/mwbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwbm_pkg
// shared widths, reset values and controller/datapath interface types
// ----------------------------------------------------------------------------
package mwbm_pkg;

   localparam int TIME_W     = 48;
   localparam int BYTES_W    = 48;
   localparam int RATE_W     = 32;
   localparam int LEN_W      = 32;
   localparam int NUM_WIN    = 4;
   localparam int WIN_IDX_W  = 2;
   localparam int SLOT_W     = 3;
   localparam int DIVIDEND_W = BYTES_W + 3;
   localparam int CSR_IDX_W  = 2;

   // slot 0..3 are the windows, the last slot is the lifetime average
   localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_AVG   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_D = 2'd3;

   localparam logic [LEN_W-1:0] WINDOW_A_RESET = 32'd30000;
   localparam logic [LEN_W-1:0] WINDOW_B_RESET = 32'd60000;
   localparam logic [LEN_W-1:0] WINDOW_C_RESET = 32'd300000;
   localparam logic [LEN_W-1:0] WINDOW_D_RESET = 32'd3600000;

   typedef struct packed {
      logic                capture;   // latch the accepted sample
      logic                eval;      // evaluate the current slot
      logic                wr_quot;   // store divider quotient into the slot
      logic                load_out;  // copy results into the output register
      logic [SLOT_W-1:0]   slot;
   } cmd_type;

   typedef struct packed {
      logic div_start;   // eval launched a division
      logic div_done;    // quotient ready this cycle
   } status_type;

endpackage

// ===== src/mwbm_div.sv =====
// ----------------------------------------------------------------------------
// mwbm_div
// restoring divider, one quotient bit per cycle, saturating 32-bit quotient
// ----------------------------------------------------------------------------
module mwbm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mwbm_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [mwbm_pkg::TIME_W-1:0]         divisor,
   output logic [mwbm_pkg::RATE_W-1:0]         quotient,
   output logic                                done
);
   import mwbm_pkg::*;

   localparam int HEAD_W = DIVIDEND_W - RATE_W;
   localparam int CNT_W  = $clog2(RATE_W + 1);

   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] div_ff, div_in;
   logic [RATE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [TIME_W-1:0] head;
   logic              saturate;
   logic [TIME_W:0]   partial;
   logic [TIME_W:0]   diff;
   logic              ge;

   // quotient overflows 32 bits exactly when the upper dividend bits reach the divisor
   assign head     = {{(TIME_W-HEAD_W){1'b0}}, dividend[DIVIDEND_W-1:RATE_W]};
   assign saturate = head >= divisor;

   assign partial = {rem_ff, quo_ff[RATE_W-1]};
   assign ge      = partial >= {1'b0, div_ff};
   assign diff    = partial - {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in = divisor;
         if (saturate) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = head;
            quo_in  = dividend[RATE_W-1:0];
            cnt_in  = CNT_W'(RATE_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[TIME_W-1:0] : partial[TIME_W-1:0];
         quo_in = {quo_ff[RATE_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== src/mwbm_datapath.sv =====
// ----------------------------------------------------------------------------
// mwbm_datapath
// window state, configuration registers, shared divider and result register
// ----------------------------------------------------------------------------
module mwbm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mwbm_pkg::cmd_type                  cmd,
   output mwbm_pkg::status_type               status,
   input  logic                               csr_write,
   input  logic [mwbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mwbm_pkg::LEN_W-1:0]         csr_data,
   input  logic [mwbm_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [mwbm_pkg::BYTES_W-1:0]       req_byte_total,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_a_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_b_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_c_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_d_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_average_kbps
);
   import mwbm_pkg::*;

   logic [LEN_W-1:0]   win_len_ff [NUM_WIN];
   logic [TIME_W-1:0]  start_time_ff [NUM_WIN];
   logic [BYTES_W-1:0] start_bytes_ff [NUM_WIN];
   logic [RATE_W-1:0]  rate_ff [NUM_WIN];
   logic [NUM_WIN-1:0] started_ff;
   logic [TIME_W-1:0]  first_time_ff;
   logic               first_valid_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [BYTES_W-1:0] total_ff;
   logic [RATE_W-1:0]  avg_ff;
   logic [RATE_W-1:0]  out_rate_ff [NUM_WIN];
   logic [RATE_W-1:0]  out_avg_ff;

   logic [WIN_IDX_W-1:0] widx;
   logic                 is_avg;
   logic [TIME_W-1:0]    cur_start;
   logic [BYTES_W-1:0]   cur_bytes;
   logic [TIME_W-1:0]    elapsed;
   logic                 fire;
   logic                 bytes_ok;
   logic [BYTES_W-1:0]   delta;
   logic                 avg_ok;
   logic [TIME_W-1:0]    avg_span;
   logic                 div_start;
   logic [DIVIDEND_W-1:0] dividend;
   logic [TIME_W-1:0]    divisor;
   logic [RATE_W-1:0]    quotient;
   logic                 div_done;

   assign widx      = cmd.slot[WIN_IDX_W-1:0];
   assign is_avg    = cmd.slot == SLOT_AVG;
   assign cur_start = start_time_ff[widx];
   assign cur_bytes = start_bytes_ff[widx];
   assign elapsed   = now_ff - cur_start;
   assign fire      = started_ff[widx] && (now_ff >= cur_start)
                      && (elapsed > {{(TIME_W-LEN_W){1'b0}}, win_len_ff[widx]});
   assign bytes_ok  = total_ff >= cur_bytes;
   assign delta     = total_ff - cur_bytes;
   assign avg_ok    = now_ff > first_time_ff;
   assign avg_span  = now_ff - first_time_ff;

   always_comb begin
      if (is_avg) begin
         div_start = cmd.eval && avg_ok;
         dividend  = {total_ff, 3'b000};
         divisor   = avg_span;
      end else begin
         div_start = cmd.eval && fire && bytes_ok;
         dividend  = {delta, 3'b000};
         divisor   = elapsed;
      end
   end

   mwbm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.div_start = div_start;
   assign status.div_done  = div_done;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff[CSR_WINDOW_A] <= WINDOW_A_RESET;
         win_len_ff[CSR_WINDOW_B] <= WINDOW_B_RESET;
         win_len_ff[CSR_WINDOW_C] <= WINDOW_C_RESET;
         win_len_ff[CSR_WINDOW_D] <= WINDOW_D_RESET;
      end else if (csr_write) begin
         win_len_ff[csr_index] <= csr_data;
      end
   end

   // control state: started bits and first-sample flag
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= '0;
         first_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture)
            first_valid_ff <= 1'b1;
         if (cmd.eval && !is_avg)
            started_ff[widx] <= 1'b1;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff   <= req_now_ms;
         total_ff <= req_byte_total;
         if (!first_valid_ff)
            first_time_ff <= req_now_ms;
      end
      if (cmd.eval) begin
         if (is_avg) begin
            if (!avg_ok)
               avg_ff <= '0;
         end else if (!started_ff[widx] || fire) begin
            start_time_ff[widx]  <= now_ff;
            start_bytes_ff[widx] <= total_ff;
            if (!started_ff[widx] || !bytes_ok)
               rate_ff[widx] <= '0;
         end
      end
      if (cmd.wr_quot) begin
         if (is_avg)
            avg_ff <= quotient;
         else
            rate_ff[widx] <= quotient;
      end
      if (cmd.load_out) begin
         out_rate_ff <= rate_ff;
         out_avg_ff  <= avg_ff;
      end
   end

   assign rsp_rate_a_kbps  = out_rate_ff[0];
   assign rsp_rate_b_kbps  = out_rate_ff[1];
   assign rsp_rate_c_kbps  = out_rate_ff[2];
   assign rsp_rate_d_kbps  = out_rate_ff[3];
   assign rsp_average_kbps = out_avg_ff;

endmodule

// ===== src/mwbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mwbm_ctrl
// sequencer: walks the four windows and the average, drives the handshakes
// ----------------------------------------------------------------------------
module mwbm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mwbm_pkg::cmd_type      cmd,
   input  mwbm_pkg::status_type   status
);
   import mwbm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVAL   = 2'd1;
   localparam logic [1:0] ST_DIVW   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cmd          = '0;
      cmd.slot     = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               slot_in     = SLOT_FIRST;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.div_start) begin
               state_in = ST_DIVW;
            end else if (slot_ff == SLOT_AVG) begin
               state_in = ST_FINISH;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_DIVW: begin
            if (status.div_done) begin
               cmd.wr_quot = 1'b1;
               if (slot_ff == SLOT_AVG) begin
                  state_in = ST_FINISH;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_EVAL;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/multi_window_bitrate_meter_core.sv =====
// ----------------------------------------------------------------------------
// multi_window_bitrate_meter_core
// four-window plus lifetime-average bitrate meter, one result per sample
// ----------------------------------------------------------------------------
// usage
//   req channel: one sample transaction per measurement, carrying the time in
//   ms and the running byte total; taken when req_valid is high and req_stall
//   is low. req_stall is high while a sample is being processed.
//   rsp channel: one result transaction per sample with the latest rate of
//   each window and the lifetime average, all in kbit/s, saturated to 32 bits.
//   csr port: csr_write with csr_index 0..3 sets window lengths a..d in ms;
//   write only while the block is idle.
// sequencing
//   a sample walks five slots (four windows, then the average) through one
//   shared divider, one quotient bit per cycle; a saturating division skips
//   the bit steps. the results then go to the output register, which sets
//   rsp_valid, and only after that is the next sample taken.
// reset
//   synchronous; window lengths return to 30 s, 1 min, 5 min and 60 min, all
//   windows become unstarted and the first-sample time is forgotten.
// stall
//   the result sits in an output register; the next sample is accepted and
//   processed while it waits, and is held before the output until rsp_stall
//   drops.
// ----------------------------------------------------------------------------
module multi_window_bitrate_meter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [mwbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mwbm_pkg::LEN_W-1:0]         csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mwbm_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [mwbm_pkg::BYTES_W-1:0]       req_byte_total,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_a_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_b_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_c_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_rate_d_kbps,
   output logic [mwbm_pkg::RATE_W-1:0]        rsp_average_kbps
);
   import mwbm_pkg::*;

   // commands from the sequencer, status back from the datapath
   cmd_type    cmd;
   status_type status;

   mwbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // window state, lengths, divider and the result register
   mwbm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_now_ms       (req_now_ms),
      .req_byte_total   (req_byte_total),
      .rsp_rate_a_kbps  (rsp_rate_a_kbps),
      .rsp_rate_b_kbps  (rsp_rate_b_kbps),
      .rsp_rate_c_kbps  (rsp_rate_c_kbps),
      .rsp_rate_d_kbps  (rsp_rate_d_kbps),
      .rsp_average_kbps (rsp_average_kbps)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the four-window bitrate meter
// ----------------------------------------------------------------------------
// a short table of directed samples (first sample, repeated and earlier times,
// exact window length, falling byte totals, saturation, zero and maximum
// window lengths) is followed by random phases. each phase first programs new
// window lengths. every accepted sample is run through a local rate predictor
// and the result transactions are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import mwbm_pkg::*;

   // row kinds of the directed table
   typedef enum logic {ROW_SAMPLE, ROW_WINDOWS} row_kind_type;

   typedef struct packed {
      logic [NUM_WIN-1:0][RATE_W-1:0] win_kbps;   // index 0 is window a
      logic [RATE_W-1:0]              avg_kbps;
   } rate_set_type;

   typedef struct packed {
      row_kind_type       kind;
      logic               typed;    // expected rates written into the row
      logic [TIME_W-1:0]  now_ms;
      logic [BYTES_W-1:0] total;
      logic [LEN_W-1:0]   len;      // all four windows, for ROW_WINDOWS rows
      rate_set_type       want;
   } plan_row_type;

   localparam logic TYPED   = 1'b1;
   localparam logic PREDICT = 1'b0;

   localparam logic [TIME_W-1:0] ALL48 = '1;
   localparam rate_set_type NO_RATES   = '0;
   localparam rate_set_type AVG_PEGGED = {{NUM_WIN*RATE_W{1'b0}}, {RATE_W{1'b1}}};

   localparam logic [CSR_IDX_W-1:0] WIN_CSR [NUM_WIN] =
      '{CSR_WINDOW_A, CSR_WINDOW_B, CSR_WINDOW_C, CSR_WINDOW_D};

   localparam int PLAN_ROWS    = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 150;
   localparam int DRAIN_CYCLES = 200;

   // directed samples, reset window lengths at the top
   localparam plan_row_type SAMPLE_PLAN [PLAN_ROWS] = '{
      // first sample: everything starts, nothing to report
      {ROW_SAMPLE,  TYPED,   48'd1000,       48'd0,          32'd0, NO_RATES},
      // same time again: average duration not positive
      {ROW_SAMPLE,  TYPED,   48'd1000,       48'd5000,       32'd0, NO_RATES},
      // time runs backwards before the first sample
      {ROW_SAMPLE,  TYPED,   48'd500,        48'd6000,       32'd0, NO_RATES},
      // one ms after the first sample with a full byte counter
      {ROW_SAMPLE,  TYPED,   48'd1001,       ALL48,          32'd0, AVG_PEGGED},
      // elapsed equal to window a: must not fire
      {ROW_SAMPLE,  PREDICT, 48'd31000,      48'd3000000,    32'd0, NO_RATES},
      // one ms past window a
      {ROW_SAMPLE,  PREDICT, 48'd31001,      48'd3750000,    32'd0, NO_RATES},
      {ROW_SAMPLE,  PREDICT, 48'd61002,      48'd7500000,    32'd0, NO_RATES},
      // byte total drops below the start of a and b
      {ROW_SAMPLE,  PREDICT, 48'd400000,     48'd100,        32'd0, NO_RATES},
      // window d fires
      {ROW_SAMPLE,  PREDICT, 48'd3700000,    48'h7FFF_FFFF_FFFF, 32'd0, NO_RATES},
      // zero window length: any forward step fires
      {ROW_WINDOWS, PREDICT, 48'd0,          48'd0,          32'd0, NO_RATES},
      {ROW_SAMPLE,  PREDICT, 48'd3700001,    48'd0,          32'd0, NO_RATES},
      // huge byte jump over one ms saturates every window
      {ROW_SAMPLE,  PREDICT, 48'd3700002,    ALL48,          32'd0, NO_RATES},
      // longest window length
      {ROW_WINDOWS, PREDICT, 48'd0,          48'd0,          32'hFFFF_FFFF, NO_RATES},
      {ROW_SAMPLE,  PREDICT, 48'd4298667298, ALL48,          32'd0, NO_RATES},
      // exactly the window length later: no fire
      {ROW_SAMPLE,  PREDICT, 48'd8593634593, 48'h0000_8000_0000, 32'd0, NO_RATES},
      {ROW_SAMPLE,  PREDICT, 48'd8593634594, 48'h0000_8000_0000, 32'd0, NO_RATES}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0]     csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic [BYTES_W-1:0]   req_byte_total = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [RATE_W-1:0]    rsp_rate_a_kbps;
   logic [RATE_W-1:0]    rsp_rate_b_kbps;
   logic [RATE_W-1:0]    rsp_rate_c_kbps;
   logic [RATE_W-1:0]    rsp_rate_d_kbps;
   logic [RATE_W-1:0]    rsp_average_kbps;

   // local copy of the meter state
   logic [LEN_W-1:0]   win_len   [NUM_WIN];
   logic [TIME_W-1:0]  win_t0    [NUM_WIN];
   logic [BYTES_W-1:0] win_b0    [NUM_WIN];
   logic [RATE_W-1:0]  win_rate  [NUM_WIN];
   logic               win_live  [NUM_WIN];
   logic [TIME_W-1:0]  first_time;
   logic               first_seen;

   rate_set_type rates_due_q [$];
   int           mismatch_count = 0;
   int           rsp_count = 0;

   // idle control: quiet turns all idling off for the last part of the run
   logic quiet = 1'b0;
   logic src_idle_on = 1'b1;
   logic sink_idle_on = 1'b1;
   int   stall_left = 0;

   multi_window_bitrate_meter_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_ms       (req_now_ms),
      .req_byte_total   (req_byte_total),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rate_a_kbps  (rsp_rate_a_kbps),
      .rsp_rate_b_kbps  (rsp_rate_b_kbps),
      .rsp_rate_c_kbps  (rsp_rate_c_kbps),
      .rsp_rate_d_kbps  (rsp_rate_d_kbps),
      .rsp_average_kbps (rsp_average_kbps)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bytes * 8 / ms, clamped to 32 bits; ms is never zero here
   function automatic logic [RATE_W-1:0] sat_rate(input logic [BYTES_W-1:0] bytes,
                                                  input logic [TIME_W-1:0] ms);
      logic [63:0] q;
      q = ({16'd0, bytes} << 3) / {16'd0, ms};
      return (q > 64'h0000_0000_FFFF_FFFF) ? {RATE_W{1'b1}} : q[RATE_W-1:0];
   endfunction

   // advance the local meter state by one sample and return its rates
   function automatic rate_set_type meter_update(input logic [TIME_W-1:0] now_ms,
                                                 input logic [BYTES_W-1:0] total);
      rate_set_type      r;
      logic [TIME_W-1:0] span;
      if (!first_seen) begin
         first_seen = 1'b1;
         first_time = now_ms;
      end
      for (int w = 0; w < NUM_WIN; w++) begin
         // an unstarted window starts here and cannot fire on this sample
         if (!win_live[w]) begin
            win_live[w] = 1'b1;
            win_rate[w] = '0;
            win_t0[w]   = now_ms;
            win_b0[w]   = total;
         end
         span = now_ms - win_t0[w];
         if (now_ms >= win_t0[w] && span > win_len[w]) begin
            // a falling byte total reports zero but still restarts the window
            win_rate[w] = (total >= win_b0[w]) ? sat_rate(total - win_b0[w], span) : '0;
            win_t0[w]   = now_ms;
            win_b0[w]   = total;
         end
         r.win_kbps[w] = win_rate[w];
      end
      r.avg_kbps = (now_ms > first_time) ? sat_rate(total, now_ms - first_time) : '0;
      return r;
   endfunction

   // drive one sample transaction, with an optional gap in front of it
   task automatic push_sample(input logic [TIME_W-1:0] now_ms,
                              input logic [BYTES_W-1:0] total,
                              input logic typed, input rate_set_type want);
      rate_set_type pred;
      if ($urandom_range(0, 19) == 0)
         src_idle_on = !src_idle_on;
      if (src_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_now_ms     <= now_ms;
      req_byte_total <= total;
      do
         @(posedge clock);
      while (req_stall);
      pred = meter_update(now_ms, total);
      rates_due_q.push_back(typed ? want : pred);
   endtask

   // program all four window lengths once every pending result is out
   task automatic set_windows(input logic [NUM_WIN-1:0][LEN_W-1:0] lens);
      req_valid <= 1'b0;
      while (rates_due_q.size() != 0)
         @(posedge clock);
      for (int w = 0; w < NUM_WIN; w++) begin
         csr_write <= 1'b1;
         csr_index <= WIN_CSR[w];
         csr_data  <= lens[w];
         @(posedge clock);
         win_len[w] = lens[w];
      end
      csr_write <= 1'b0;
   endtask

   task automatic check_field(input string field, input logic [RATE_W-1:0] want,
                              input logic [RATE_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result %0d %s mismatch, expected %0d, got %0d",
                     $realtime, rsp_count, field, want, got);
      end
   endtask

   // result side: random stall bursts
   always @(posedge clock) begin
      if ($urandom_range(0, 29) == 0)
         sink_idle_on <= !sink_idle_on;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (sink_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare every accepted result transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rate_set_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rates_due_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result transaction with nothing expected", $realtime);
         end else begin
            due = rates_due_q.pop_front();
            check_field("rate_a_kbps", due.win_kbps[0], rsp_rate_a_kbps);
            check_field("rate_b_kbps", due.win_kbps[1], rsp_rate_b_kbps);
            check_field("rate_c_kbps", due.win_kbps[2], rsp_rate_c_kbps);
            check_field("rate_d_kbps", due.win_kbps[3], rsp_rate_d_kbps);
            check_field("average_kbps", due.avg_kbps, rsp_average_kbps);
         end
         rsp_count++;
      end
   end

   // main sequence
   initial begin
      logic [NUM_WIN-1:0][LEN_W-1:0] lens;
      logic [TIME_W-1:0]             cur_t;
      logic [BYTES_W-1:0]            cur_b;
      logic [31:0]                   step_max;
      logic [31:0]                   bytes_max;
      logic [31:0]                   scale;
      logic [31:0]                   delta;
      int                            sel;

      // state after reset
      win_len[0] = WINDOW_A_RESET;
      win_len[1] = WINDOW_B_RESET;
      win_len[2] = WINDOW_C_RESET;
      win_len[3] = WINDOW_D_RESET;
      for (int w = 0; w < NUM_WIN; w++) begin
         win_t0[w]   = '0;
         win_b0[w]   = '0;
         win_rate[w] = '0;
         win_live[w] = 1'b0;
      end
      first_time = '0;
      first_seen = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (SAMPLE_PLAN[i]) begin
         if (SAMPLE_PLAN[i].kind == ROW_WINDOWS)
            set_windows({NUM_WIN{SAMPLE_PLAN[i].len}});
         else
            push_sample(SAMPLE_PLAN[i].now_ms, SAMPLE_PLAN[i].total,
                        SAMPLE_PLAN[i].typed, SAMPLE_PLAN[i].want);
      end

      // random phases, each with its own window lengths and pace
      cur_t = SAMPLE_PLAN[PLAN_ROWS-1].now_ms;
      cur_b = '0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               lens      = {WINDOW_D_RESET, WINDOW_C_RESET, WINDOW_B_RESET, WINDOW_A_RESET};
               step_max  = 20000;
               bytes_max = 2000000;
            end
            1: begin
               lens      = {NUM_WIN{32'd1}};
               step_max  = 3;
               bytes_max = 50;
            end
            2: begin
               lens      = {NUM_WIN{32'hFFFF_FFFF}};
               step_max  = 32'h4000_0000;
               bytes_max = 32'hFFFF_FFFF;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       scale = 16;
                  1:       scale = 500;
                  2:       scale = 40000;
                  default: scale = 2000000;
               endcase
               for (int w = 0; w < NUM_WIN; w++)
                  lens[w] = $urandom_range(1, scale);
               step_max = scale / 2 + 1;
               case ($urandom_range(0, 3))
                  0:       bytes_max = 0;
                  1:       bytes_max = 1000;
                  2:       bytes_max = 32'h0010_0000;
                  default: bytes_max = 32'hFFFF_FFFF;
               endcase
            end
         endcase
         // last phase runs flat out on both sides
         if (p == PHASES - 1)
            quiet = 1'b1;
         set_windows(lens);
         repeat (PHASE_ITEMS) begin
            // mostly forward in time, sometimes back, sometimes a long jump
            sel   = $urandom_range(0, 99);
            delta = $urandom_range(0, step_max);
            if (sel < 4) begin
               if (cur_t > 48'(delta))
                  cur_t = cur_t - 48'(delta);
            end else if (sel < 8) begin
               cur_t = cur_t + 48'($urandom());
            end else begin
               cur_t = cur_t + 48'(delta);
            end
            // byte total: steady growth, rare bursts and rare drops
            sel = $urandom_range(0, 99);
            if (sel < 6)
               cur_b = 48'({$urandom(), $urandom()});
            else if (sel < 10)
               cur_b = cur_b + {16'($urandom()), $urandom()};
            else
               cur_b = cur_b + 48'($urandom_range(0, bytes_max));
            push_sample(cur_t, cur_b, PREDICT, NO_RATES);
         end
      end

      // top of the time range, then back to zero
      set_windows({NUM_WIN{32'd5}});
      push_sample(ALL48, ALL48, PREDICT, NO_RATES);
      push_sample('0, '0, PREDICT, NO_RATES);

      req_valid <= 1'b0;
      while (rates_due_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("multi_window_bitrate_meter_core test passed");
      else
         $display("multi_window_bitrate_meter_core test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("multi_window_bitrate_meter_core test failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/mwbm_pkg.sv
src/mwbm_div.sv
src/mwbm_datapath.sv
src/mwbm_ctrl.sv
src/multi_window_bitrate_meter_core.sv
bench/tb_top.sv
